/* rtl/ppid_pkg.sv */
package ppid_pkg;

	localparam int unsigned ValW   = 14;
	localparam int unsigned GainW  = 16;
	localparam int unsigned DriveW = 16;
	localparam int unsigned ErrW   = 15;
	localparam int unsigned DiffW  = 16;
	localparam int unsigned SumW   = 32;
	localparam int unsigned IdxW   = 3;
	localparam int unsigned TotW   = 51;
	localparam int unsigned Shift  = 8;

	localparam logic [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
	localparam logic [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

	typedef enum logic [IdxW-1:0] {
		REG_PROP_GAIN     = 3'd0,
		REG_INTEG_GAIN    = 3'd1,
		REG_DERIV_GAIN    = 3'd2,
		REG_DEAD_ZONE     = 3'd3,
		REG_INTEGRAL_BAND = 3'd4,
		REG_OUTPUT_LIMIT  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [GainW-1:0]  prop_gain;
		logic [GainW-1:0]  integ_gain;
		logic [GainW-1:0]  deriv_gain;
		logic [ValW-1:0]   dead_zone;
		logic [ValW-1:0]   integral_band;
		logic [DriveW-1:0] output_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [ErrW-1:0] prev_error;
		logic signed [SumW-1:0] error_sum;
		logic [DriveW-1:0]      prev_drive;
	} pid_state_t;

endpackage

/* rtl/ppid_cfg.sv */
module ppid_cfg
	import ppid_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [IdxW-1:0] wr_index,
	input  logic [15:0]     wr_data,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= '0;
			cfg_q.integ_gain    <= '0;
			cfg_q.deriv_gain    <= '0;
			cfg_q.dead_zone     <= '0;
			cfg_q.integral_band <= '0;
			cfg_q.output_limit  <= '1;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_PROP_GAIN:     cfg_q.prop_gain     <= wr_data[GainW-1:0];
				REG_INTEG_GAIN:    cfg_q.integ_gain    <= wr_data[GainW-1:0];
				REG_DERIV_GAIN:    cfg_q.deriv_gain    <= wr_data[GainW-1:0];
				REG_DEAD_ZONE:     cfg_q.dead_zone     <= wr_data[ValW-1:0];
				REG_INTEGRAL_BAND: cfg_q.integral_band <= wr_data[ValW-1:0];
				REG_OUTPUT_LIMIT:  cfg_q.output_limit  <= wr_data[DriveW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/ppid_calc.sv */
module ppid_calc
	import ppid_pkg::*;
(
	input  cfg_t              cfg,
	input  logic [ValW-1:0]   target,
	input  logic [ValW-1:0]   feedback,
	input  pid_state_t        cur,
	output pid_state_t        nxt,
	output logic [DriveW-1:0] drive
);

	logic signed [ErrW-1:0]   err;
	logic [ValW-1:0]          mag;
	logic                     outside;
	logic                     in_band;
	logic                     at_limit;
	logic                     idle;
	logic                     add_ok;
	logic [SumW:0]            sum_wide;
	logic [SumW-1:0]          sum_sat;
	logic signed [SumW-1:0]   sum_next;
	logic signed [GainW:0]    kp_s;
	logic signed [GainW:0]    ki_s;
	logic signed [GainW:0]    kd_s;
	logic signed [DiffW-1:0]  diff;
	logic signed [31:0]       p_term;
	logic signed [32:0]       d_term;
	logic signed [48:0]       i_term;
	logic signed [TotW-1:0]   p_ext;
	logic signed [TotW-1:0]   d_ext;
	logic signed [TotW-1:0]   i_ext;
	logic [TotW-1:0]          total;
	logic                     positive;
	logic [TotW-Shift-1:0]    scaled;
	logic [DriveW-1:0]        clamped;

	assign err = $signed({1'b0, target}) - $signed({1'b0, feedback});
	assign mag = err[ErrW-1] ? ValW'(-err) : err[ValW-1:0];

	assign outside  = mag > cfg.dead_zone;
	assign in_band  = mag < cfg.integral_band;
	assign at_limit = cur.prev_drive >= cfg.output_limit;
	assign idle     = cur.prev_drive == '0;

	// A saturated drive only lets the sum unwind; an idle drive only lets it grow.
	assign add_ok = at_limit ? err[ErrW-1]
	              : (idle ? (!err[ErrW-1] && (err != '0)) : 1'b1);

	assign sum_wide = {cur.error_sum[SumW-1], cur.error_sum}
	                + {{(SumW+1-ErrW){err[ErrW-1]}}, err};
	assign sum_sat  = (sum_wide[SumW] != sum_wide[SumW-1])
	                ? (sum_wide[SumW] ? SumMin : SumMax) : sum_wide[SumW-1:0];
	assign sum_next = (outside && in_band && add_ok) ? $signed(sum_sat) : cur.error_sum;

	assign kp_s = $signed({1'b0, cfg.prop_gain});
	assign ki_s = $signed({1'b0, cfg.integ_gain});
	assign kd_s = $signed({1'b0, cfg.deriv_gain});
	assign diff = $signed({err[ErrW-1], err})
	            - $signed({cur.prev_error[ErrW-1], cur.prev_error});

	assign p_term = 32'(kp_s) * 32'(err);
	assign d_term = 33'(kd_s) * 33'(diff);
	assign i_term = 49'(ki_s) * 49'(sum_next);

	assign p_ext = TotW'(p_term);
	assign d_ext = TotW'(d_term);
	assign i_ext = in_band ? TotW'(i_term) : '0;
	assign total = p_ext + d_ext + i_ext;

	assign positive = !total[TotW-1] && (total != '0);
	assign scaled   = total[TotW-1:Shift];
	assign clamped  = (scaled > (TotW-Shift)'(cfg.output_limit))
	                ? cfg.output_limit : scaled[DriveW-1:0];

	assign drive = (outside && positive) ? clamped : '0;

	assign nxt.prev_error = err;
	assign nxt.error_sum  = sum_next;
	assign nxt.prev_drive = drive;

endmodule

/* rtl/positional_pid_with_antiwindup_top.sv */
// Positional PID controller with dead zone, integral separation and conditional
// anti-windup. Each sample beat (target, feedback) is captured in an input register;
// the whole control update, including the saturating 32-bit error sum and the three
// gain products, is combinational between that register and the drive register, and a
// new sample is taken every cycle unless drive_stall holds the output. The loop through
// the error sum and the previous drive is closed through the state register. The user
// writes gains and thresholds through the configuration channel only while no sample
// is in flight; the block itself does not enforce this, and cfg_ready is always high.
module positional_pid_with_antiwindup_top
	import ppid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  logic [ValW-1:0]   target,
	input  logic [ValW-1:0]   feedback,
	output logic              drive_valid,
	input  logic              drive_stall,
	output logic [DriveW-1:0] drive,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IdxW-1:0]   cfg_index,
	input  logic [15:0]       cfg_data
);

	cfg_t              cfg;
	pid_state_t        state_q;
	pid_state_t        state_nxt;
	logic              valid_s1;
	logic [ValW-1:0]   target_s1;
	logic [ValW-1:0]   feedback_s1;
	logic              drive_valid_q;
	logic [DriveW-1:0] drive_q;
	logic [DriveW-1:0] drive_calc;
	logic              advance;
	logic              take;

	assign cfg_ready = 1'b1;

	ppid_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ppid_calc u_calc (
		.cfg      (cfg),
		.target   (target_s1),
		.feedback (feedback_s1),
		.cur      (state_q),
		.nxt      (state_nxt),
		.drive    (drive_calc)
	);

	assign advance      = valid_s1 && (!drive_valid_q || !drive_stall);
	assign sample_stall = valid_s1 && !advance;
	assign take         = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			target_s1   <= target;
			feedback_s1 <= feedback;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= '0;
			drive_valid_q <= 1'b0;
		end else if (advance) begin
			state_q       <= state_nxt;
			drive_valid_q <= 1'b1;
		end else if (!drive_stall) begin
			drive_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= drive_calc;
		end
	end

	assign drive_valid = drive_valid_q;
	assign drive       = drive_q;

endmodule

/* rtl/ppid_checker.sv */
module ppid_checker
	import ppid_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_stall,
	input logic              drive_valid,
	input logic              drive_stall,
	input logic [DriveW-1:0] drive,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic [IdxW-1:0]   cfg_index,
	input logic [15:0]       cfg_data
);

	logic [1:0]        pending_q;
	logic [DriveW-1:0] limit_q;
	logic              in_beat;
	logic              out_beat;

	assign in_beat  = sample_valid && !sample_stall;
	assign out_beat = drive_valid && !drive_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '1;
		end else if (cfg_valid && cfg_ready && (cfg_index == REG_OUTPUT_LIMIT)) begin
			limit_q <= cfg_data[DriveW-1:0];
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive_stall |=> drive_valid && $stable(drive))
		else $error("drive beat changed while stalled");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> drive <= limit_q)
		else $error("drive beat above the output limit");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> pending_q != 2'd0)
		else $error("drive beat without an outstanding sample");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 2'd2)
		else $error("more samples in flight than the datapath holds");

endmodule

bind positional_pid_with_antiwindup_top ppid_checker u_ppid_checker (.*);

/* tb/ppid_drive_checker.sv */
`timescale 1ns / 100ps

module ppid_drive_checker
	import ppid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  logic              sample_stall,
	input  logic [ValW-1:0]   target,
	input  logic [ValW-1:0]   feedback,
	input  logic              drive_valid,
	input  logic              drive_stall,
	input  logic [DriveW-1:0] drive,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [IdxW-1:0]   cfg_index,
	input  logic [15:0]       cfg_data,
	output int                fail_count,
	output int                pending,
	output int                beats_checked
);

	logic [GainW-1:0]       kp;
	logic [GainW-1:0]       ki;
	logic [GainW-1:0]       kd;
	logic [ValW-1:0]        dz;
	logic [ValW-1:0]        band;
	logic [DriveW-1:0]      lim;
	logic signed [ErrW-1:0] last_err;
	int                     integ_sum;
	logic [DriveW-1:0]      last_drive;
	logic [DriveW-1:0]      expected_drives[$];

	initial begin
		fail_count    = 0;
		pending       = 0;
		beats_checked = 0;
	end

	function automatic int sat_accumulate(input int acc, input int step);
		longint s;
		s = longint'(acc) + longint'(step);
		if (s > longint'($signed(SumMax)))
			return $signed(SumMax);
		if (s < longint'($signed(SumMin)))
			return $signed(SumMin);
		return int'(s);
	endfunction

	function automatic logic [DriveW-1:0] predict_drive(input logic [ValW-1:0] t,
			input logic [ValW-1:0] f);
		int                err;
		int                mag;
		logic              in_band;
		longint            total;
		longint            scaled;
		logic [DriveW-1:0] d_out;
		err   = int'(t) - int'(f);
		mag   = (err < 0) ? -err : err;
		d_out = '0;
		if (mag > int'(dz)) begin
			in_band = (mag < int'(band));
			if (in_band) begin
				if (last_drive >= lim) begin
					if (err < 0)
						integ_sum = sat_accumulate(integ_sum, err);
				end else if (last_drive == '0) begin
					if (err > 0)
						integ_sum = sat_accumulate(integ_sum, err);
				end else begin
					integ_sum = sat_accumulate(integ_sum, err);
				end
			end
			total = longint'(kp) * err + longint'(kd) * (err - int'(last_err));
			if (in_band)
				total += longint'(ki) * integ_sum;
			if (total > 0) begin
				scaled = total >>> Shift;
				d_out  = (scaled > longint'(lim)) ? lim : DriveW'(scaled);
			end
		end
		last_err   = err[ErrW-1:0];
		last_drive = d_out;
		return d_out;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [DriveW-1:0] want;
		if (!arst_n) begin
			kp         = '0;
			ki         = '0;
			kd         = '0;
			dz         = '0;
			band       = '0;
			lim        = '1;
			last_err   = '0;
			integ_sum  = 0;
			last_drive = '0;
			expected_drives.delete();
			pending    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_PROP_GAIN:     kp   = cfg_data;
					REG_INTEG_GAIN:    ki   = cfg_data;
					REG_DERIV_GAIN:    kd   = cfg_data;
					REG_DEAD_ZONE:     dz   = cfg_data[ValW-1:0];
					REG_INTEGRAL_BAND: band = cfg_data[ValW-1:0];
					REG_OUTPUT_LIMIT:  lim  = cfg_data;
					default: ;
				endcase
			end
			if (drive_valid && !drive_stall) begin
				beats_checked++;
				if (expected_drives.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected drive beat: got %0d", drive);
				end else begin
					want = expected_drives.pop_front();
					if (drive !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("drive mismatch: expected %0d, got %0d", want, drive);
					end
				end
			end
			if (sample_valid && !sample_stall)
				expected_drives.push_back(predict_drive(target, feedback));
			pending = expected_drives.size();
		end
	end

endmodule

/* tb/tb_positional_pid_with_antiwindup_top.sv */
`timescale 1ns / 100ps

module tb_positional_pid_with_antiwindup_top;
	import ppid_pkg::*;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	logic [ValW-1:0]   target       = '0;
	logic [ValW-1:0]   feedback     = '0;
	logic              drive_valid;
	logic              drive_stall  = 1'b0;
	logic [DriveW-1:0] drive;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic [IdxW-1:0]   cfg_index    = '0;
	logic [15:0]       cfg_data     = '0;

	int   fail_count;
	int   pending;
	int   beats_checked;
	logic calm         = 1'b0;
	int   cur_dz       = 0;
	int   cur_band     = 0;
	int   settings_cnt = 0;

	always #5 clk = ~clk;

	positional_pid_with_antiwindup_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.target       (target),
		.feedback     (feedback),
		.drive_valid  (drive_valid),
		.drive_stall  (drive_stall),
		.drive        (drive),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	ppid_drive_checker drive_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.target        (target),
		.feedback      (feedback),
		.drive_valid   (drive_valid),
		.drive_stall   (drive_stall),
		.drive         (drive),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.beats_checked (beats_checked)
	);

	always @(negedge clk) begin
		drive_stall <= !calm && ($urandom_range(99) < 28);
	end

	task automatic offer_sample(input int t, input int f);
		while (!calm && $urandom_range(99) < 28) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		target       <= t[ValW-1:0];
		feedback     <= f[ValW-1:0];
		do @(posedge clk); while (sample_stall);
		@(negedge clk);
	endtask

	task automatic offer_error(input int sp, input int e);
		int f;
		f = sp - e;
		if (f < 0)
			f = 0;
		if (f > 16383)
			f = 16383;
		offer_sample(sp, f);
	endtask

	task automatic wait_idle();
		sample_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[15:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic load_settings(input int kp, input int ki, input int kd, input int dz,
			input int band, input int lim);
		wait_idle();
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		write_reg(REG_DERIV_GAIN, kd);
		write_reg(REG_DEAD_ZONE, dz);
		write_reg(REG_INTEGRAL_BAND, band);
		write_reg(REG_OUTPUT_LIMIT, lim);
		cfg_valid <= 1'b0;
		cur_dz   = dz;
		cur_band = band;
		settings_cnt++;
	endtask

	initial begin
		#20_000_000;
		$display("tb_positional_pid_with_antiwindup_top: done, errors");
		$finish;
	end

	initial begin
		int sp;
		int e;
		int r;
		int span;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		load_settings(256, 16, 128, 4, 200, 200);
		offer_sample(0, 0);
		offer_sample(100, 96);
		offer_sample(100, 95);
		offer_sample(96, 100);
		offer_sample(95, 100);
		offer_sample(16383, 0);
		offer_sample(0, 16383);
		offer_sample(5000, 4800);
		offer_sample(5000, 4801);
		repeat (5) offer_sample(5000, 4850);
		repeat (3) offer_sample(4850, 5000);
		offer_sample(8191, 8192);
		offer_sample(8192, 8191);
		offer_sample(16383, 16383);
		offer_sample(9000, 8000);
		offer_sample(0, 0);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: load_settings($urandom_range(2048), $urandom_range(256),
					$urandom_range(1024), $urandom_range(16), $urandom_range(32, 4000),
					$urandom_range(64, 65535));
				1: load_settings(65535, 65535, 65535, 0, 16383, 65535);
				2: load_settings(0, 0, 0, 0, 0, 0);
				3: load_settings($urandom_range(65535), $urandom_range(65535),
					$urandom_range(65535), 16383, 16383, $urandom_range(65535));
				4: load_settings($urandom_range(65535), $urandom_range(65535),
					$urandom_range(65535), $urandom_range(300), $urandom_range(16383),
					$urandom_range(65535));
				default: load_settings($urandom_range(4096), $urandom_range(512),
					$urandom_range(4096), $urandom_range(8), $urandom_range(100, 16383),
					$urandom_range(255));
			endcase
			calm = (p == 4);
			sp   = $urandom_range(16383);
			repeat (285) begin
				r = $urandom_range(99);
				if (r < 60) begin
					span = cur_band + cur_dz + 16;
					if (span > 16383)
						span = 16383;
					e = $urandom_range(2 * span);
					offer_error(sp, e - span);
				end else if (r < 75) begin
					case ($urandom_range(3))
						0: e = cur_dz;
						1: e = cur_dz + 1;
						2: e = cur_band - 1;
						default: e = cur_band;
					endcase
					if ($urandom_range(1))
						e = -e;
					offer_error(sp, e);
				end else if (r < 80) begin
					sp = $urandom_range(16383);
					offer_sample(sp, $urandom_range(16383));
				end else begin
					offer_sample($urandom_range(16383), $urandom_range(16383));
				end
			end
		end

		wait_idle();
		$display("%0d drive beats checked under %0d register settings,", beats_checked,
			settings_cnt);
		$display("including dead zone and band edges, output clamps and a stall-free stretch.");
		if (fail_count == 0 && pending == 0) begin
			$display("tb_positional_pid_with_antiwindup_top: done, clean");
		end else begin
			$display("tb_positional_pid_with_antiwindup_top: done, errors");
		end
		$finish;
	end

endmodule
